FILE: rtl/ubt_pkg.sv
package ubt_pkg;

   localparam int ACTION_W = 2;
   localparam int LEVEL_W = 6;
   localparam int HANDLE_W = 12;
   localparam int STATUS_W = 3;
   localparam int LIVE_W = 13;
   localparam int TERM_W = 5;
   localparam int STAMP_W = 32;
   localparam int HASH_W = 32;
   localparam int REQ_TDATA_W = 48;
   localparam int RSP_TDATA_W = 32;

   localparam int NODE_COUNT_DEF = 4096;
   localparam int BUCKET_COUNT_DEF = 4096;
   localparam int MAX_LEVEL_DEF = 63;

   localparam logic [TERM_W-1:0] TERM_RESET = 5'd2;
   localparam logic [TERM_W-1:0] TERM_MIN = 5'd1;
   localparam logic [TERM_W-1:0] TERM_MAX = 5'd16;
   localparam logic [STAMP_W-1:0] ROUND_RESET = 32'd1;

   localparam logic [HASH_W-1:0] HASH_MUL_LV = 32'h9E37_79B1;
   localparam logic [HASH_W-1:0] HASH_MUL_LO = 32'h85EB_CA77;
   localparam logic [HASH_W-1:0] HASH_MUL_HI = 32'hC2B2_AE3D;

   localparam logic [ACTION_W-1:0] ACT_FIND = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_ROUND = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_MARK = 2'd2;
   localparam logic [ACTION_W-1:0] ACT_SWEEP = 2'd3;

   localparam logic [STATUS_W-1:0] ST_FOUND = 3'd0;
   localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd1;
   localparam logic [STATUS_W-1:0] ST_REDUCED = 3'd2;
   localparam logic [STATUS_W-1:0] ST_FULL = 3'd3;
   localparam logic [STATUS_W-1:0] ST_DONE = 3'd4;

   typedef struct packed {
      logic level;
      logic children;
      logic link;
      logic stamp;
   } node_wmask_type;

   function automatic logic [TERM_W-1:0] eff_terms(input logic [TERM_W-1:0] t);
      logic [TERM_W-1:0] r;
      r = t;
      if (t < TERM_MIN) begin
         r = TERM_MIN;
      end else if (t > TERM_MAX) begin
         r = TERM_MAX;
      end
      return r;
   endfunction

endpackage

FILE: rtl/ubt_hash.sv
module ubt_hash #(
   parameter int BUCKET_COUNT = ubt_pkg::BUCKET_COUNT_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             go,
   input  logic [ubt_pkg::LEVEL_W-1:0]      level,
   input  logic [ubt_pkg::HANDLE_W-1:0]     low,
   input  logic [ubt_pkg::HANDLE_W-1:0]     high,
   output logic                             valid,
   output logic [$clog2(BUCKET_COUNT)-1:0]  bucket
);

   localparam int BW = $clog2(BUCKET_COUNT);
   localparam int HW = ubt_pkg::HASH_W;

   logic          v1_ff, v2_ff, v3_ff;
   logic [HW-1:0] p_lv_ff, p_lo_ff, p_hi_ff, p_hi2_ff, h2_ff, h4_ff;
   logic [HW-1:0] p_lv_in, p_lo_in, p_hi_in, h2_in, h3, h4_in;

   // stage 1: the three products, stage 2 and 3: the mixing rounds
   always_comb begin
      p_lv_in = HW'(HW'(level) * ubt_pkg::HASH_MUL_LV);
      p_lo_in = HW'(HW'(low) * ubt_pkg::HASH_MUL_LO);
      p_hi_in = HW'(HW'(high) * ubt_pkg::HASH_MUL_HI);
      h2_in = p_lv_ff ^ (p_lo_ff + (p_lv_ff << 6) + (p_lv_ff >> 2));
      h3 = h2_ff ^ (p_hi2_ff + (h2_ff << 6) + (h2_ff >> 2));
      h4_in = h3 ^ (h3 >> 15);
   end

   always_ff @(posedge clock) begin
      p_lv_ff <= p_lv_in;
      p_lo_ff <= p_lo_in;
      p_hi_ff <= p_hi_in;
      h2_ff <= h2_in;
      p_hi2_ff <= p_hi_ff;
      h4_ff <= h4_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= go;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   assign valid = v3_ff;
   assign bucket = h4_ff[BW-1:0];

endmodule

FILE: rtl/ubt_node_mem.sv
module ubt_node_mem #(
   parameter int NODE_COUNT = ubt_pkg::NODE_COUNT_DEF
) (
   input  logic                              clock,
   input  logic [$clog2(NODE_COUNT)-1:0]     raddr,
   output logic [ubt_pkg::LEVEL_W-1:0]       rlevel,
   output logic [ubt_pkg::HANDLE_W-1:0]      rlow,
   output logic [ubt_pkg::HANDLE_W-1:0]      rhigh,
   output logic [$clog2(NODE_COUNT)-1:0]     rlink,
   output logic [ubt_pkg::STAMP_W-1:0]       rstamp,
   input  logic                              we,
   input  ubt_pkg::node_wmask_type           wmask,
   input  logic [$clog2(NODE_COUNT)-1:0]     waddr,
   input  logic [ubt_pkg::LEVEL_W-1:0]       wlevel,
   input  logic [ubt_pkg::HANDLE_W-1:0]      wlow,
   input  logic [ubt_pkg::HANDLE_W-1:0]      whigh,
   input  logic [$clog2(NODE_COUNT)-1:0]     wlink,
   input  logic [ubt_pkg::STAMP_W-1:0]       wstamp
);

   localparam int AW = $clog2(NODE_COUNT);

   logic [ubt_pkg::LEVEL_W-1:0]  level_mem [NODE_COUNT];
   logic [ubt_pkg::HANDLE_W-1:0] low_mem   [NODE_COUNT];
   logic [ubt_pkg::HANDLE_W-1:0] high_mem  [NODE_COUNT];
   logic [AW-1:0]                link_mem  [NODE_COUNT];
   logic [ubt_pkg::STAMP_W-1:0]  stamp_mem [NODE_COUNT];

   always_ff @(posedge clock) begin
      if (we && wmask.level) begin
         level_mem[waddr] <= wlevel;
      end
      if (we && wmask.children) begin
         low_mem[waddr] <= wlow;
         high_mem[waddr] <= whigh;
      end
      if (we && wmask.link) begin
         link_mem[waddr] <= wlink;
      end
      if (we && wmask.stamp) begin
         stamp_mem[waddr] <= wstamp;
      end
   end

   always_ff @(posedge clock) begin
      rlevel <= level_mem[raddr];
      rlow <= low_mem[raddr];
      rhigh <= high_mem[raddr];
      rlink <= link_mem[raddr];
      rstamp <= stamp_mem[raddr];
   end

endmodule

FILE: rtl/ubt_bucket_mem.sv
module ubt_bucket_mem #(
   parameter int NODE_COUNT = ubt_pkg::NODE_COUNT_DEF,
   parameter int BUCKET_COUNT = ubt_pkg::BUCKET_COUNT_DEF
) (
   input  logic                              clock,
   input  logic [$clog2(BUCKET_COUNT)-1:0]   raddr,
   output logic [$clog2(NODE_COUNT)-1:0]     rdata,
   input  logic                              we,
   input  logic [$clog2(BUCKET_COUNT)-1:0]   waddr,
   input  logic [$clog2(NODE_COUNT)-1:0]     wdata
);

   logic [$clog2(NODE_COUNT)-1:0] head_mem [BUCKET_COUNT];

   always_ff @(posedge clock) begin
      if (we) begin
         head_mem[waddr] <= wdata;
      end
      rdata <= head_mem[raddr];
   end

endmodule

FILE: rtl/bdd_unique_table_engine.sv
// channel  dir  handshake                 payload
// req      in   req_tvalid / req_tready   tuser action, tdata level, low, high, root
// rsp      out  rsp_tvalid / rsp_tready   tuser status, tdata handle, live count
// csr      in   csr_wen                   csr_wdata terminal count
//
// one item at a time, req_tready high only in idle; find_or_insert hashes the node,
// reads the bucket head, compares each chain node in turn and on a miss allocates a
// slot, reading a reused free one's link (3-stage hash, registered memory reads);
// mark_root reads each marked node; sweep reads each slot and unchains a freed one
// reset or a csr write clears the bucket heads, req_tready low
// a result held in the rsp register only delays the finish of the next item
module bdd_unique_table_engine #(
   parameter int NODE_COUNT = ubt_pkg::NODE_COUNT_DEF,
   parameter int BUCKET_COUNT = ubt_pkg::BUCKET_COUNT_DEF,
   parameter int MAX_LEVEL = ubt_pkg::MAX_LEVEL_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // level [5:0], low_child [17:6], high_child [29:18], root_handle [41:30]
   input  logic [ubt_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // action [1:0]
   input  logic [ubt_pkg::ACTION_W-1:0]       req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // handle [11:0], live_count [24:12]
   output logic [ubt_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   // status [2:0]
   output logic [ubt_pkg::STATUS_W-1:0]       rsp_tuser,
   input  logic                               csr_wen,
   input  logic [ubt_pkg::TERM_W-1:0]         csr_wdata
);

   localparam int AW = $clog2(NODE_COUNT);
   localparam int BW = $clog2(BUCKET_COUNT);
   localparam int SW = (MAX_LEVEL + 1 > 1) ? $clog2(MAX_LEVEL + 1) : 1;
   localparam int DW = $clog2(MAX_LEVEL + 2);
   localparam int CW = (AW + 1 > ubt_pkg::HANDLE_W) ? AW + 1 : ubt_pkg::HANDLE_W;
   localparam int LW = ubt_pkg::LEVEL_W;
   localparam int HDW = ubt_pkg::HANDLE_W;
   localparam int TW = ubt_pkg::TERM_W;

   typedef enum logic [19:0] {
      S_CLEAR  = 20'h00001,
      S_IDLE   = 20'h00002,
      S_HASH   = 20'h00004,
      S_BKT    = 20'h00008,
      S_CMP    = 20'h00010,
      S_ALLOC  = 20'h00020,
      S_FREE   = 20'h00040,
      S_WRITE  = 20'h00080,
      S_PCHK   = 20'h00100,
      S_PRD    = 20'h00200,
      S_POP    = 20'h00400,
      S_POPRD  = 20'h00800,
      S_NRD    = 20'h01000,
      S_SWNEXT = 20'h02000,
      S_SWRD   = 20'h04000,
      S_ULHASH = 20'h08000,
      S_ULBKT  = 20'h10000,
      S_ULWALK = 20'h20000,
      S_SWFREE = 20'h40000,
      S_DONE   = 20'h80000
   } state_type;

   state_type state_ff, state_in;

   logic [TW-1:0]      term_ff, term_in, tc;
   logic [AW-1:0]      free_head_ff, free_head_in;
   logic [AW:0]        next_slot_ff, next_slot_in;
   logic [31:0]        round_ff, round_in;
   logic [DW-1:0]      depth_ff, depth_in;
   logic [BW-1:0]      clr_ff, clr_in;
   logic               hs_go_ff, hs_go_in;
   logic [LW-1:0]      lv_ff, lv_in;
   logic [HDW-1:0]     lo_ff, lo_in, hi_ff, hi_in, cand_ff, cand_in;
   logic               phase_low_ff, phase_low_in;
   logic [BW-1:0]      bkt_ff, bkt_in;
   logic [AW-1:0]      bkt_head_ff, bkt_head_in, cur_ff, cur_in, prev_ff, prev_in;
   logic [AW-1:0]      link_ff, link_in, slot_ff, slot_in;
   logic [AW:0]        steps_ff, steps_in, u_ff, u_in, live_ff, live_in;
   logic [HDW-1:0]     res_handle_ff, res_handle_in, rsp_handle_ff, rsp_handle_in;
   logic [ubt_pkg::STATUS_W-1:0] res_status_ff, res_status_in;
   logic [ubt_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [ubt_pkg::LIVE_W-1:0]   res_live_ff, res_live_in, rsp_live_ff, rsp_live_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic [AW-1:0]      nm_raddr, nm_rlink, nm_waddr, nm_wlink;
   logic [LW-1:0]      nm_rlevel, nm_wlevel;
   logic [HDW-1:0]     nm_rlow, nm_rhigh, nm_wlow, nm_whigh;
   logic [31:0]        nm_rstamp, nm_wstamp;
   logic               nm_we;
   ubt_pkg::node_wmask_type nm_wmask;

   logic [BW-1:0]      bm_raddr, bm_waddr;
   logic [AW-1:0]      bm_rdata, bm_wdata;
   logic               bm_we;

   logic [AW-1:0]      stack_mem [MAX_LEVEL + 1];
   logic [AW-1:0]      stk_rdata_ff;
   logic [SW-1:0]      stk_raddr, stk_waddr;
   logic [AW-1:0]      stk_wdata;
   logic               stk_we;

   logic               hs_valid;
   logic [BW-1:0]      hs_bucket;

   logic [AW:0]        steps_nx;
   logic               cand_ok;

   ubt_hash #(.BUCKET_COUNT(BUCKET_COUNT)) u_hash (
      .clock  (clock),
      .reset  (reset),
      .go     (hs_go_ff),
      .level  (lv_ff),
      .low    (lo_ff),
      .high   (hi_ff),
      .valid  (hs_valid),
      .bucket (hs_bucket)
   );

   ubt_node_mem #(.NODE_COUNT(NODE_COUNT)) u_node_mem (
      .clock  (clock),
      .raddr  (nm_raddr),
      .rlevel (nm_rlevel),
      .rlow   (nm_rlow),
      .rhigh  (nm_rhigh),
      .rlink  (nm_rlink),
      .rstamp (nm_rstamp),
      .we     (nm_we),
      .wmask  (nm_wmask),
      .waddr  (nm_waddr),
      .wlevel (nm_wlevel),
      .wlow   (nm_wlow),
      .whigh  (nm_whigh),
      .wlink  (nm_wlink),
      .wstamp (nm_wstamp)
   );

   ubt_bucket_mem #(.NODE_COUNT(NODE_COUNT), .BUCKET_COUNT(BUCKET_COUNT)) u_bucket_mem (
      .clock (clock),
      .raddr (bm_raddr),
      .rdata (bm_rdata),
      .we    (bm_we),
      .waddr (bm_waddr),
      .wdata (bm_wdata)
   );

   always_ff @(posedge clock) begin
      if (stk_we) begin
         stack_mem[stk_waddr] <= stk_wdata;
      end
      stk_rdata_ff <= stack_mem[stk_raddr];
   end

   assign tc = ubt_pkg::eff_terms(term_ff);
   assign req_tready = (state_ff == S_IDLE);
   assign steps_nx = steps_ff + 1'b1;
   assign cand_ok = (CW'(cand_ff) >= CW'(tc)) && (CW'(cand_ff) < CW'(next_slot_ff));

   always_comb begin
      state_in = state_ff;
      term_in = term_ff;
      free_head_in = free_head_ff;
      next_slot_in = next_slot_ff;
      round_in = round_ff;
      depth_in = depth_ff;
      clr_in = clr_ff;
      hs_go_in = 1'b0;
      lv_in = lv_ff;
      lo_in = lo_ff;
      hi_in = hi_ff;
      cand_in = cand_ff;
      phase_low_in = phase_low_ff;
      bkt_in = bkt_ff;
      bkt_head_in = bkt_head_ff;
      cur_in = cur_ff;
      prev_in = prev_ff;
      link_in = link_ff;
      slot_in = slot_ff;
      steps_in = steps_ff;
      u_in = u_ff;
      live_in = live_ff;
      res_handle_in = res_handle_ff;
      res_status_in = res_status_ff;
      res_live_in = res_live_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_handle_in = rsp_handle_ff;
      rsp_status_in = rsp_status_ff;
      rsp_live_in = rsp_live_ff;

      nm_raddr = cur_ff;
      nm_we = 1'b0;
      nm_wmask = '0;
      nm_waddr = slot_ff;
      nm_wlevel = lv_ff;
      nm_wlow = lo_ff;
      nm_whigh = hi_ff;
      nm_wlink = bkt_head_ff;
      nm_wstamp = round_ff;
      bm_raddr = bkt_ff;
      bm_we = 1'b0;
      bm_waddr = bkt_ff;
      bm_wdata = slot_ff;
      stk_raddr = SW'(depth_ff - 1'b1);
      stk_we = 1'b0;
      stk_waddr = SW'(depth_ff);
      stk_wdata = AW'(cand_ff);

      unique case (state_ff)
         S_CLEAR: begin
            bm_we = 1'b1;
            bm_waddr = clr_ff;
            bm_wdata = '0;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == BW'(BUCKET_COUNT - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_tvalid) begin
               lv_in = req_tdata[5:0];
               lo_in = req_tdata[17:6];
               hi_in = req_tdata[29:18];
               cand_in = req_tdata[41:30];
               res_handle_in = '0;
               res_status_in = ubt_pkg::ST_DONE;
               res_live_in = '0;
               unique case (req_tuser)
                  ubt_pkg::ACT_FIND: begin
                     if (req_tdata[17:6] == req_tdata[29:18]) begin
                        res_handle_in = req_tdata[17:6];
                        res_status_in = ubt_pkg::ST_REDUCED;
                        state_in = S_DONE;
                     end else if (req_tdata[5:0] == '0) begin
                        res_status_in = ubt_pkg::ST_FULL;
                        state_in = S_DONE;
                     end else begin
                        hs_go_in = 1'b1;
                        state_in = S_HASH;
                     end
                  end
                  ubt_pkg::ACT_ROUND: begin
                     round_in = round_ff + 1'b1;
                     state_in = S_DONE;
                  end
                  ubt_pkg::ACT_MARK: begin
                     depth_in = '0;
                     phase_low_in = 1'b0;
                     state_in = S_PCHK;
                  end
                  ubt_pkg::ACT_SWEEP: begin
                     live_in = '0;
                     free_head_in = '0;
                     u_in = next_slot_ff;
                     state_in = S_SWNEXT;
                  end
               endcase
            end
         end
         S_HASH: begin
            if (hs_valid) begin
               bkt_in = hs_bucket;
               bm_raddr = hs_bucket;
               state_in = S_BKT;
            end
         end
         S_BKT: begin
            bkt_head_in = bm_rdata;
            cur_in = bm_rdata;
            steps_in = '0;
            nm_raddr = bm_rdata;
            state_in = (bm_rdata == '0) ? S_ALLOC : S_CMP;
         end
         S_CMP: begin
            if (nm_rlevel == lv_ff && nm_rlow == lo_ff && nm_rhigh == hi_ff) begin
               res_handle_in = HDW'(cur_ff);
               res_status_in = ubt_pkg::ST_FOUND;
               state_in = S_DONE;
            end else if (nm_rlink == '0 || steps_nx >= (AW + 1)'(NODE_COUNT)) begin
               state_in = S_ALLOC;
            end else begin
               steps_in = steps_nx;
               cur_in = nm_rlink;
               nm_raddr = nm_rlink;
            end
         end
         S_ALLOC: begin
            nm_raddr = free_head_ff;
            if (free_head_ff != '0) begin
               slot_in = free_head_ff;
               state_in = S_FREE;
            end else if (next_slot_ff < (AW + 1)'(NODE_COUNT)) begin
               slot_in = AW'(next_slot_ff);
               next_slot_in = next_slot_ff + 1'b1;
               state_in = S_WRITE;
            end else begin
               res_handle_in = '0;
               res_status_in = ubt_pkg::ST_FULL;
               state_in = S_DONE;
            end
         end
         S_FREE: begin
            free_head_in = nm_rlink;
            state_in = S_WRITE;
         end
         S_WRITE: begin
            nm_we = 1'b1;
            nm_wmask = '1;
            bm_we = 1'b1;
            res_handle_in = HDW'(slot_ff);
            res_status_in = ubt_pkg::ST_INSERTED;
            state_in = S_DONE;
         end
         S_PCHK: begin
            nm_raddr = AW'(cand_ff);
            if (cand_ok) begin
               state_in = S_PRD;
            end else if (phase_low_ff) begin
               cand_in = hi_ff;
               phase_low_in = 1'b0;
            end else begin
               state_in = S_POP;
            end
         end
         S_PRD: begin
            if (nm_rlevel != '0 && nm_rstamp != round_ff
                  && depth_ff < DW'(MAX_LEVEL + 1)) begin
               nm_we = 1'b1;
               nm_wmask.stamp = 1'b1;
               nm_waddr = AW'(cand_ff);
               stk_we = 1'b1;
               depth_in = depth_ff + 1'b1;
            end
            if (phase_low_ff) begin
               cand_in = hi_ff;
               phase_low_in = 1'b0;
               state_in = S_PCHK;
            end else begin
               state_in = S_POP;
            end
         end
         S_POP: begin
            if (depth_ff == '0) begin
               state_in = S_DONE;
            end else begin
               depth_in = depth_ff - 1'b1;
               state_in = S_POPRD;
            end
         end
         S_POPRD: begin
            nm_raddr = stk_rdata_ff;
            state_in = S_NRD;
         end
         S_NRD: begin
            cand_in = nm_rlow;
            hi_in = nm_rhigh;
            phase_low_in = 1'b1;
            state_in = S_PCHK;
         end
         S_SWNEXT: begin
            nm_raddr = AW'(u_ff - 1'b1);
            if (u_ff > (AW + 1)'(tc)) begin
               u_in = u_ff - 1'b1;
               state_in = S_SWRD;
            end else begin
               res_live_in = ubt_pkg::LIVE_W'(live_ff);
               state_in = S_DONE;
            end
         end
         S_SWRD: begin
            if (nm_rlevel != '0 && nm_rstamp == round_ff) begin
               live_in = live_ff + 1'b1;
               state_in = S_SWNEXT;
            end else if (nm_rlevel != '0) begin
               lv_in = nm_rlevel;
               lo_in = nm_rlow;
               hi_in = nm_rhigh;
               link_in = nm_rlink;
               hs_go_in = 1'b1;
               state_in = S_ULHASH;
            end else begin
               state_in = S_SWFREE;
            end
         end
         S_ULHASH: begin
            if (hs_valid) begin
               bkt_in = hs_bucket;
               bm_raddr = hs_bucket;
               state_in = S_ULBKT;
            end
         end
         S_ULBKT: begin
            nm_raddr = bm_rdata;
            bm_wdata = link_ff;
            if (bm_rdata == '0) begin
               state_in = S_SWFREE;
            end else if (bm_rdata == AW'(u_ff)) begin
               bm_we = 1'b1;
               state_in = S_SWFREE;
            end else begin
               prev_in = bm_rdata;
               steps_in = (AW + 1)'(1);
               state_in = S_ULWALK;
            end
         end
         S_ULWALK: begin
            nm_raddr = nm_rlink;
            nm_waddr = prev_ff;
            nm_wlink = link_ff;
            if (nm_rlink == '0 || steps_ff >= (AW + 1)'(NODE_COUNT)) begin
               state_in = S_SWFREE;
            end else if (nm_rlink == AW'(u_ff)) begin
               nm_we = 1'b1;
               nm_wmask.link = 1'b1;
               state_in = S_SWFREE;
            end else begin
               prev_in = nm_rlink;
               steps_in = steps_nx;
            end
         end
         S_SWFREE: begin
            nm_we = 1'b1;
            nm_wmask.level = 1'b1;
            nm_wmask.link = 1'b1;
            nm_waddr = AW'(u_ff);
            nm_wlevel = '0;
            nm_wlink = free_head_ff;
            free_head_in = AW'(u_ff);
            state_in = S_SWNEXT;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_handle_in = res_handle_ff;
               rsp_status_in = res_status_ff;
               rsp_live_in = res_live_ff;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase

      // register write restarts the store
      if (csr_wen) begin
         term_in = csr_wdata;
         free_head_in = '0;
         next_slot_in = (AW + 1)'(ubt_pkg::eff_terms(csr_wdata));
         round_in = ubt_pkg::ROUND_RESET;
         depth_in = '0;
         clr_in = '0;
         state_in = S_CLEAR;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         term_ff <= ubt_pkg::TERM_RESET;
         free_head_ff <= '0;
         next_slot_ff <= (AW + 1)'(ubt_pkg::TERM_RESET);
         round_ff <= ubt_pkg::ROUND_RESET;
         depth_ff <= '0;
         clr_ff <= '0;
         hs_go_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         term_ff <= term_in;
         free_head_ff <= free_head_in;
         next_slot_ff <= next_slot_in;
         round_ff <= round_in;
         depth_ff <= depth_in;
         clr_ff <= clr_in;
         hs_go_ff <= hs_go_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lv_ff <= lv_in;
      lo_ff <= lo_in;
      hi_ff <= hi_in;
      cand_ff <= cand_in;
      phase_low_ff <= phase_low_in;
      bkt_ff <= bkt_in;
      bkt_head_ff <= bkt_head_in;
      cur_ff <= cur_in;
      prev_ff <= prev_in;
      link_ff <= link_in;
      slot_ff <= slot_in;
      steps_ff <= steps_in;
      u_ff <= u_in;
      live_ff <= live_in;
      res_handle_ff <= res_handle_in;
      res_status_ff <= res_status_in;
      res_live_ff <= res_live_in;
      rsp_handle_ff <= rsp_handle_in;
      rsp_status_ff <= rsp_status_in;
      rsp_live_ff <= rsp_live_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser = rsp_status_ff;
   assign rsp_tdata = {7'd0, rsp_live_ff, rsp_handle_ff};

   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      depth_ff <= DW'(MAX_LEVEL + 1))
      else $error("mark stack depth out of range");

   a_next_slot_bound: assert property (@(posedge clock) disable iff (reset)
      next_slot_ff <= (AW + 1)'(NODE_COUNT) && next_slot_ff != '0)
      else $error("next slot out of range");

   a_free_below_next: assert property (@(posedge clock) disable iff (reset)
      (free_head_ff != '0 && state_ff == S_IDLE) |-> (AW + 1)'(free_head_ff) < next_slot_ff)
      else $error("free list head above allocated range");

   a_hash_expected: assert property (@(posedge clock) disable iff (reset)
      hs_valid |-> (state_ff == S_HASH || state_ff == S_ULHASH || csr_wen))
      else $error("hash result outside a hash wait");

endmodule

FILE: tb/sv/bdd_unique_table_checker.sv
module bdd_unique_table_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   input  logic                              req_tready,
   input  logic [ubt_pkg::REQ_TDATA_W-1:0]   req_tdata,
   input  logic [ubt_pkg::ACTION_W-1:0]      req_tuser,
   input  logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic [ubt_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   input  logic [ubt_pkg::STATUS_W-1:0]      rsp_tuser,
   input  logic                              csr_wen,
   input  logic [ubt_pkg::TERM_W-1:0]        csr_wdata,
   output int                                fail_count,
   output int                                outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NODES = ubt_pkg::NODE_COUNT_DEF;
   localparam int BUCKETS = ubt_pkg::BUCKET_COUNT_DEF;
   localparam int STACK_DEPTH = ubt_pkg::MAX_LEVEL_DEF + 1;
   localparam int HW = ubt_pkg::HANDLE_W;

   typedef struct packed {
      logic [ubt_pkg::HANDLE_W-1:0] handle;
      logic [ubt_pkg::STATUS_W-1:0] status;
      logic [ubt_pkg::LIVE_W-1:0]   live;
   } node_result_type;

   logic [ubt_pkg::LEVEL_W-1:0]  lvl_mem [NODES];
   logic [HW-1:0]                lo_mem [NODES];
   logic [HW-1:0]                hi_mem [NODES];
   logic [HW-1:0]                link_mem [NODES];
   logic [ubt_pkg::STAMP_W-1:0]  stamp_mem [NODES];
   logic [HW-1:0]                bucket_mem [BUCKETS];
   logic [HW-1:0]                walk_stack [STACK_DEPTH];
   int                           walk_sp;
   int                           terms;
   int                           free_list;
   int                           next_free_slot;
   logic [ubt_pkg::STAMP_W-1:0]  round_no;
   node_result_type              expected_q [$];

   function automatic void clear_store(input logic [ubt_pkg::TERM_W-1:0] t);
      for (int i = 0; i < NODES; i++) begin
         lvl_mem[i] = '0; lo_mem[i] = '0; hi_mem[i] = '0;
         link_mem[i] = '0; stamp_mem[i] = '0;
      end
      for (int i = 0; i < BUCKETS; i++) bucket_mem[i] = '0;
      terms = (t < 1) ? 1 : (t > 16) ? 16 : int'(t);
      free_list = 0;
      next_free_slot = terms;
      round_no = 32'd1;
      walk_sp = 0;
   endfunction

   function automatic int bucket_index(input logic [31:0] lv, lo, hi);
      logic [31:0] h;
      h = lv * 32'h9E3779B1;
      h = h ^ (lo * 32'h85EBCA77 + (h << 6) + (h >> 2));
      h = h ^ (hi * 32'hC2B2AE3D + (h << 6) + (h >> 2));
      h = h ^ (h >> 15);
      return int'(h % BUCKETS);
   endfunction

   function automatic void push_live(input int h);
      if (h < terms || h >= next_free_slot || h >= NODES) return;
      if (lvl_mem[h] == 0 || stamp_mem[h] == round_no) return;
      if (walk_sp >= STACK_DEPTH) return;
      stamp_mem[h] = round_no;
      walk_stack[walk_sp] = h;
      walk_sp++;
   endfunction

   function automatic void mark_from(input int root);
      int x;
      walk_sp = 0;
      push_live(root);
      while (walk_sp > 0) begin
         walk_sp--;
         x = walk_stack[walk_sp];
         push_live(lo_mem[x]);
         push_live(hi_mem[x]);
      end
   endfunction

   function automatic void unchain(input int h);
      int b, prev, cur, steps;
      b = bucket_index(lvl_mem[h], lo_mem[h], hi_mem[h]);
      prev = 0;
      cur = bucket_mem[b];
      steps = 0;
      while (cur != 0 && steps < NODES) begin
         if (cur == h) begin
            if (prev != 0) link_mem[prev] = link_mem[h];
            else bucket_mem[b] = link_mem[h];
            return;
         end
         prev = cur;
         cur = link_mem[cur];
         steps++;
      end
   endfunction

   function automatic int sweep_count();
      int live, u;
      live = 0;
      u = next_free_slot;
      free_list = 0;
      while (u > terms) begin
         u--;
         if (lvl_mem[u] != 0 && stamp_mem[u] == round_no) begin
            live++;
         end else begin
            if (lvl_mem[u] != 0) unchain(u);
            lvl_mem[u] = '0;
            link_mem[u] = free_list[HW-1:0];
            free_list = u;
         end
      end
      return live;
   endfunction

   function automatic node_result_type lookup_insert(input int lv, lo, hi);
      node_result_type r;
      int b, cur, steps, slot;
      r = '{handle: '0, status: ubt_pkg::ST_FULL, live: '0};
      if (lo == hi) return '{handle: lo[HW-1:0], status: ubt_pkg::ST_REDUCED, live: '0};
      if (lv == 0) return r;
      b = bucket_index(lv, lo, hi);
      cur = bucket_mem[b];
      steps = 0;
      while (cur != 0 && steps < NODES) begin
         if (lvl_mem[cur] == lv && lo_mem[cur] == lo && hi_mem[cur] == hi)
            return '{handle: cur[HW-1:0], status: ubt_pkg::ST_FOUND, live: '0};
         cur = link_mem[cur];
         steps++;
      end
      if (free_list != 0) begin
         slot = free_list;
         free_list = link_mem[slot];
      end else if (next_free_slot < NODES) begin
         slot = next_free_slot;
         next_free_slot++;
      end else begin
         return r;
      end
      lvl_mem[slot] = lv[ubt_pkg::LEVEL_W-1:0];
      lo_mem[slot] = lo[HW-1:0];
      hi_mem[slot] = hi[HW-1:0];
      stamp_mem[slot] = round_no;
      link_mem[slot] = bucket_mem[b];
      bucket_mem[b] = slot[HW-1:0];
      return '{handle: slot[HW-1:0], status: ubt_pkg::ST_INSERTED, live: '0};
   endfunction

   function automatic node_result_type predict(input logic [ubt_pkg::ACTION_W-1:0] act,
                                               input logic [ubt_pkg::REQ_TDATA_W-1:0] d);
      node_result_type r;
      r = '{handle: '0, status: ubt_pkg::ST_DONE, live: '0};
      unique case (act)
         ubt_pkg::ACT_FIND: begin
            r = lookup_insert(d[5:0], d[17:6], d[29:18]);
         end
         ubt_pkg::ACT_ROUND: begin
            round_no = round_no + 1;
         end
         ubt_pkg::ACT_MARK: begin
            mark_from(d[41:30]);
         end
         ubt_pkg::ACT_SWEEP: begin
            r.live = sweep_count();
         end
      endcase
      return r;
   endfunction

   assign outstanding = expected_q.size();

   always @(posedge clock) begin
      node_result_type want, got;
      if (reset) begin
         clear_store(ubt_pkg::TERM_RESET);
         expected_q.delete();
         fail_count = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = '{handle: rsp_tdata[11:0], status: rsp_tuser, live: rsp_tdata[24:12]};
            if (expected_q.size() == 0) begin
               $display("%0t: unexpected result beat %p", $time, got);
               fail_count++;
            end else begin
               want = expected_q.pop_front();
               if (got.handle !== want.handle || got.status !== want.status ||
                   got.live !== want.live) begin
                  $display("%0t: mismatch expected %p actual %p", $time, want, got);
                  fail_count++;
               end
            end
         end
         if (req_tvalid && req_tready) expected_q.push_back(predict(req_tuser, req_tdata));
         if (csr_wen) clear_store(csr_wdata);
      end
   end

endmodule

FILE: tb/sv/tb_bdd_unique_table_engine.sv
module tb_bdd_unique_table_engine;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ACT_W = ubt_pkg::ACTION_W;

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               req_tvalid = 1'b0;
   logic                               req_tready;
   logic [ubt_pkg::REQ_TDATA_W-1:0]    req_tdata = '0;
   logic [ubt_pkg::ACTION_W-1:0]       req_tuser = ubt_pkg::ACT_FIND;
   logic                               rsp_tvalid;
   logic                               rsp_tready = 1'b0;
   logic [ubt_pkg::RSP_TDATA_W-1:0]    rsp_tdata;
   logic [ubt_pkg::STATUS_W-1:0]       rsp_tuser;
   logic                               csr_wen = 1'b0;
   logic [ubt_pkg::TERM_W-1:0]         csr_wdata = '0;
   int                                 fail_count;
   int                                 outstanding;
   int                                 send_idle_pct = 29;
   int                                 recv_idle_pct = 75;
   int                                 hold_off = 0;
   int                                 cycle_count = 0;
   logic [29:0]                        issued [$];

   always #5 clock = ~clock;

   bdd_unique_table_engine u_top (.*);

   bdd_unique_table_checker u_chk (.*);

   always @(posedge clock) begin
      if (hold_off > 0) begin
         rsp_tready <= 1'b0;
         hold_off <= hold_off - 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 3000000) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   task automatic send_beat(input logic [ubt_pkg::ACTION_W-1:0] act,
                            input int lv, lo, hi, root);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= act;
      req_tdata <= {6'd0, root[11:0], hi[11:0], lo[11:0], lv[5:0]};
      if (act == ubt_pkg::ACT_FIND) issued.push_back({hi[11:0], lo[11:0], lv[5:0]});
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_terms(input logic [ubt_pkg::TERM_W-1:0] v);
      drain();
      csr_wen <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_wen <= 1'b0;
      issued.delete();
   endtask

   task automatic gc_cycle(input int spread);
      send_beat(ubt_pkg::ACT_ROUND, 0, 0, 0, 0);
      repeat ($urandom_range(3)) send_beat(ubt_pkg::ACT_MARK, 0, 0, 0, $urandom_range(spread));
      send_beat(ubt_pkg::ACT_SWEEP, 0, 0, 0, 0);
   endtask

   task automatic random_items(input int n);
      logic [29:0] t;
      int pick, spread;
      for (int i = 0; i < n; i++) begin
         pick = $urandom_range(99);
         spread = 20 + issued.size() / 4;
         if (spread > 4095) spread = 4095;
         if (pick < 55) begin
            send_beat(ubt_pkg::ACT_FIND, $urandom_range(1, 63), $urandom_range(spread),
                      $urandom_range(spread), 0);
         end else if (pick < 70 && issued.size() > 0) begin
            t = issued[$urandom_range(issued.size() - 1)];
            send_beat(ubt_pkg::ACT_FIND, t[5:0], t[17:6], t[29:18], 0);
         end else if (pick < 80) begin
            gc_cycle(spread);
         end else if (pick < 90) begin
            send_beat(ubt_pkg::ACT_FIND, $urandom_range(63), $urandom_range(4095),
                      $urandom_range(4095), $urandom_range(4095));
         end else begin
            send_beat(ACT_W'($urandom_range(1, 3)), $urandom_range(63), $urandom_range(4095),
                      $urandom_range(4095), $urandom_range(4095));
         end
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      send_beat(ubt_pkg::ACT_FIND, 5, 7, 7, 0);
      send_beat(ubt_pkg::ACT_FIND, 0, 3, 9, 0);
      send_beat(ubt_pkg::ACT_FIND, 0, 4095, 4095, 0);
      send_beat(ubt_pkg::ACT_FIND, 1, 0, 1, 0);
      send_beat(ubt_pkg::ACT_FIND, 1, 0, 1, 0);
      send_beat(ubt_pkg::ACT_FIND, 63, 4095, 0, 4095);
      send_beat(ubt_pkg::ACT_FIND, 2, 2, 3, 0);
      send_beat(ubt_pkg::ACT_FIND, 3, 4, 2, 0);
      send_beat(ubt_pkg::ACT_FIND, 1, 5, 5, 0);
      send_beat(ubt_pkg::ACT_FIND, 2, 6, 6, 0);
      send_beat(ubt_pkg::ACT_FIND, 1, 6, 5, 0);
      send_beat(ubt_pkg::ACT_ROUND, 0, 0, 0, 0);
      send_beat(ubt_pkg::ACT_MARK, 0, 0, 0, 5);
      send_beat(ubt_pkg::ACT_MARK, 0, 0, 0, 1);
      send_beat(ubt_pkg::ACT_MARK, 0, 0, 0, 4095);
      send_beat(ubt_pkg::ACT_MARK, 0, 0, 0, 5);
      send_beat(ubt_pkg::ACT_SWEEP, 0, 0, 0, 0);
      send_beat(ubt_pkg::ACT_FIND, 7, 1, 0, 0);
      send_beat(ubt_pkg::ACT_FIND, 1, 0, 1, 0);
      send_beat(ubt_pkg::ACT_FIND, 63, 4095, 0, 0);
      send_beat(ubt_pkg::ACT_SWEEP, 0, 0, 0, 0);

      drain();
      random_items(150);

      hold_off <= 400;
      repeat (12) send_beat(ubt_pkg::ACT_FIND, $urandom_range(1, 63), $urandom_range(30),
                            $urandom_range(30), 0);
      drain();

      write_terms(5'd0);
      send_idle_pct = 75;
      recv_idle_pct = 29;
      random_items(110);
      write_terms(5'd16);
      random_items(110);
      write_terms(5'd31);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      random_items(70);

      write_terms(5'd16);
      send_beat(ubt_pkg::ACT_ROUND, 0, 0, 0, 0);
      send_beat(ubt_pkg::ACT_MARK, 0, 0, 0, 100);
      send_beat(ubt_pkg::ACT_SWEEP, 0, 0, 0, 0);
      random_items(25);
      write_terms(ubt_pkg::TERM_RESET);
      random_items(25);

      drain();
      repeat (50) @(posedge clock);
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

FILE: files.f
rtl/ubt_pkg.sv
rtl/ubt_hash.sv
rtl/ubt_node_mem.sv
rtl/ubt_bucket_mem.sv
rtl/bdd_unique_table_engine.sv
tb/sv/bdd_unique_table_checker.sv
tb/sv/tb_bdd_unique_table_engine.sv
